>>> hdl/lsra_pkg.sv
// Shared types, constants and helper functions of the linear-scan register assigner.
// Used by every module and interface of the block; depends on nothing.
`default_nettype none

package lsra_pkg;

  // Sizes of the register files and the active list
  localparam int REG_COUNT    = 32;
  localparam int ACTIVE_DEPTH = 32;
  localparam int MASK_W       = 32;
  localparam int REG_W        = 5;
  localparam int POS_W        = 16;
  localparam int EXP_W        = 6;
  localparam int COUNT_W      = $clog2(ACTIVE_DEPTH + 1);
  localparam int CFG_IDX_W    = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INT_USABLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLT_USABLE = 1'b1;

  // Reset values of the usable masks
  localparam logic [MASK_W-1:0] INT_USABLE_RESET = 32'h0000_FFEF;
  localparam logic [MASK_W-1:0] FLT_USABLE_RESET = 32'h0000_00FF;

  // Registers that may be candidates at all
  localparam logic [MASK_W-1:0] REG_WINDOW = (REG_COUNT >= MASK_W) ? {MASK_W{1'b1}} :
      MASK_W'((64'd1 << REG_COUNT) - 64'd1);

  // Register file select
  localparam logic FILE_INT = 1'b0;
  localparam logic FILE_FLT = 1'b1;

  // One entry of the active list
  typedef struct packed {
    logic [POS_W-1:0] end_pos;
    logic [REG_W-1:0] reg_idx;
    logic             file;
  } lsra_entry_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic expire;
    logic select;
    logic commit;
  } lsra_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic expire_hit;
    logic slot_free;
  } lsra_status_t;

  // Lowest set bit of a mask: returns {found, index}
  function automatic logic [REG_W:0] find_first(input logic [MASK_W-1:0] v);
    logic [MASK_W-1:0] onehot;
    logic [REG_W-1:0]  idx;
    onehot = v & (~v + MASK_W'(1));
    idx    = '0;
    for (int i = 0; i < MASK_W; i++) begin
      if (onehot[i]) begin
        idx = idx | REG_W'(i);
      end
    end
    return {(v != '0), idx};
  endfunction

endpackage

`default_nettype wire

>>> hdl/lsra_item_if.sv
// Input channel of the register assigner: one live interval per transaction.
// Depends on lsra_pkg for field widths.
`default_nettype none

interface lsra_item_if;
  logic                        valid;
  logic                        ready;
  logic                        begin_function;
  logic [lsra_pkg::POS_W-1:0]  range_start;
  logic [lsra_pkg::POS_W-1:0]  range_end;
  logic                        fp_file;

  modport source (output valid, begin_function, range_start, range_end, fp_file,
                  input ready);
  modport sink   (input valid, begin_function, range_start, range_end, fp_file,
                  output ready);
endinterface

`default_nettype wire

>>> hdl/lsra_result_if.sv
// Output channel of the register assigner: one grant result per transaction.
// Depends on lsra_pkg for field widths.
`default_nettype none

interface lsra_result_if;
  logic                        valid;
  logic                        ready;
  logic                        granted;
  logic [lsra_pkg::REG_W-1:0]  reg_index;
  logic [lsra_pkg::EXP_W-1:0]  expired_count;

  modport source (output valid, granted, reg_index, expired_count, input ready);
  modport sink   (input valid, granted, reg_index, expired_count, output ready);
endinterface

`default_nettype wire

>>> hdl/lsra_cfg_if.sv
// Configuration write channel of the register assigner.
// Depends on lsra_pkg for index and data widths.
`default_nettype none

interface lsra_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [lsra_pkg::CFG_IDX_W-1:0]  index;
  logic [lsra_pkg::MASK_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> hdl/lsra_active_list.sv
// Active interval list kept sorted by end position, as a row of cells.
// Pops one entry from the front per cycle, inserts one entry in sorted place.
// Depends on lsra_pkg.
`default_nettype none

module lsra_active_list (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          clear,
  input  wire logic                          pop,
  input  wire logic                          push,
  input  wire lsra_pkg::lsra_entry_t         push_entry,
  input  wire logic [lsra_pkg::POS_W-1:0]    start_pos,
  output      logic                          head_hit,
  output      lsra_pkg::lsra_entry_t         head_entry,
  output      logic                          full,
  output      logic [lsra_pkg::COUNT_W-1:0]  count
);

  lsra_pkg::lsra_entry_t entries [lsra_pkg::ACTIVE_DEPTH];
  logic [lsra_pkg::ACTIVE_DEPTH-1:0] le;

  // Mark live cells whose end does not exceed the new end (a prefix)
  always_comb begin
    for (int i = 0; i < lsra_pkg::ACTIVE_DEPTH; i++) begin
      le[i] = (lsra_pkg::COUNT_W'(i) < count) &&
              (entries[i].end_pos <= push_entry.end_pos);
    end
  end

  assign head_entry = entries[0];
  assign head_hit   = (count != '0) && (entries[0].end_pos < start_pos);
  assign full       = (count == lsra_pkg::COUNT_W'(lsra_pkg::ACTIVE_DEPTH));

  // Shift left on pop, open a slot and insert on push
  always_ff @(posedge clk) begin
    for (int i = 0; i < lsra_pkg::ACTIVE_DEPTH; i++) begin
      if (pop) begin
        if (i < lsra_pkg::ACTIVE_DEPTH - 1) begin
          entries[i] <= entries[i+1];
        end
      end else if (push && !le[i]) begin
        if (i == 0) begin
          entries[i] <= push_entry;
        end else if (le[i-1]) begin
          entries[i] <= push_entry;
        end else begin
          entries[i] <= entries[i-1];
        end
      end
    end
  end

  // Track the number of live entries
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      count <= '0;
    end else if (pop) begin
      count <= count - lsra_pkg::COUNT_W'(1);
    end else if (push) begin
      count <= count + lsra_pkg::COUNT_W'(1);
    end
  end

endmodule

`default_nettype wire

>>> hdl/lsra_dpath.sv
// Datapath of the register assigner: usable, free, used and locked masks,
// register selection, the active list and the result register.
// Depends on lsra_pkg and lsra_active_list.
`default_nettype none

module lsra_dpath (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire lsra_pkg::lsra_cmd_t             cmd,
  output      lsra_pkg::lsra_status_t          status,
  // interval fields
  input  wire logic                            begin_function,
  input  wire logic [lsra_pkg::POS_W-1:0]      range_start,
  input  wire logic [lsra_pkg::POS_W-1:0]      range_end,
  input  wire logic                            fp_file,
  // configuration writes
  input  wire logic                            cfg_valid,
  input  wire logic [lsra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lsra_pkg::MASK_W-1:0]     cfg_data,
  // result register
  output      logic                            out_valid,
  input  wire logic                            out_ready,
  output      logic                            granted,
  output      logic [lsra_pkg::REG_W-1:0]      reg_index,
  output      logic [lsra_pkg::EXP_W-1:0]      expired_count
);

  logic [lsra_pkg::MASK_W-1:0] int_usable, flt_usable;
  logic [lsra_pkg::MASK_W-1:0] int_free, int_used, int_locked;
  logic [lsra_pkg::MASK_W-1:0] flt_free, flt_used, flt_locked;
  logic [lsra_pkg::POS_W-1:0]  cur_start, cur_end;
  logic                        cur_file;
  logic [lsra_pkg::EXP_W-1:0]  exp_cnt;
  logic                        sel_found;
  logic [lsra_pkg::REG_W-1:0]  sel_idx;

  logic                          head_hit, list_full;
  lsra_pkg::lsra_entry_t         head_entry, new_entry;
  logic [lsra_pkg::COUNT_W-1:0]  active_count;
  logic [lsra_pkg::MASK_W-1:0]   cand;
  logic [lsra_pkg::REG_W:0]      pick_used, pick_any;
  logic                          clear_sets;

  assign clear_sets = cmd.load && begin_function;

  // Take configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      int_usable <= lsra_pkg::INT_USABLE_RESET;
      flt_usable <= lsra_pkg::FLT_USABLE_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        lsra_pkg::CFG_INT_USABLE: int_usable <= cfg_data;
        lsra_pkg::CFG_FLT_USABLE: flt_usable <= cfg_data;
        default: ;
      endcase
    end
  end

  // Latch the interval on acceptance
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_start <= range_start;
      cur_end   <= range_end;
      cur_file  <= fp_file;
    end
  end

  // Count expired intervals of the current transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      exp_cnt <= '0;
    end else if (cmd.expire) begin
      exp_cnt <= exp_cnt + lsra_pkg::EXP_W'(1);
    end
  end

  // Pick lowest free unlocked register, preferring one already used
  always_comb begin
    if (cur_file == lsra_pkg::FILE_FLT) begin
      cand = flt_free & ~flt_locked & lsra_pkg::REG_WINDOW;
      pick_used = lsra_pkg::find_first(cand & flt_used);
    end else begin
      cand = int_free & ~int_locked & lsra_pkg::REG_WINDOW;
      pick_used = lsra_pkg::find_first(cand & int_used);
    end
    pick_any = lsra_pkg::find_first(cand);
  end

  always_ff @(posedge clk) begin
    if (cmd.select) begin
      sel_found <= pick_any[lsra_pkg::REG_W] && !list_full;
      sel_idx   <= pick_used[lsra_pkg::REG_W] ? pick_used[lsra_pkg::REG_W-1:0]
                                              : pick_any[lsra_pkg::REG_W-1:0];
    end
  end

  // Free, used and locked masks of both files
  always_ff @(posedge clk) begin
    if (rst) begin
      int_free   <= '1;
      flt_free   <= '1;
      int_used   <= '0;
      flt_used   <= '0;
      int_locked <= ~lsra_pkg::INT_USABLE_RESET;
      flt_locked <= ~lsra_pkg::FLT_USABLE_RESET;
    end else if (clear_sets) begin
      int_free   <= '1;
      flt_free   <= '1;
      int_locked <= ~int_usable;
      flt_locked <= ~flt_usable;
    end else if (cmd.expire) begin
      if (head_entry.file == lsra_pkg::FILE_FLT) begin
        flt_free[head_entry.reg_idx] <= 1'b1;
      end else begin
        int_free[head_entry.reg_idx] <= 1'b1;
      end
    end else if (cmd.commit && sel_found) begin
      if (cur_file == lsra_pkg::FILE_FLT) begin
        flt_free[sel_idx] <= 1'b0;
        flt_used[sel_idx] <= 1'b1;
      end else begin
        int_free[sel_idx] <= 1'b0;
        int_used[sel_idx] <= 1'b1;
      end
    end
  end

  assign new_entry = '{end_pos: cur_end, reg_idx: sel_idx, file: cur_file};

  lsra_active_list u_active (
    .clk        (clk),
    .rst        (rst),
    .clear      (clear_sets),
    .pop        (cmd.expire),
    .push       (cmd.commit && sel_found),
    .push_entry (new_entry),
    .start_pos  (cur_start),
    .head_hit   (head_hit),
    .head_entry (head_entry),
    .full       (list_full),
    .count      (active_count)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      granted       <= sel_found;
      reg_index     <= sel_found ? sel_idx : '0;
      expired_count <= exp_cnt;
    end
  end

  assign status.expire_hit = head_hit;
  assign status.slot_free  = !out_valid || out_ready;

  // The list never grows past its depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    active_count <= lsra_pkg::COUNT_W'(lsra_pkg::ACTIVE_DEPTH))
    else $error("active list count beyond depth");

  // A result is never written over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  // Only a live head that ends before start is expired
  a_expire_hit: assert property (@(posedge clk) disable iff (rst)
    cmd.expire |-> (active_count != '0) && head_hit)
    else $error("expire without a live expiring head");

  // A granted integer register is no longer free afterward
  a_grant_taken: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && sel_found && cur_file == lsra_pkg::FILE_INT) |=> !int_free[reg_index])
    else $error("granted integer register still free");

endmodule

`default_nettype wire

>>> hdl/lsra_ctrl.sv
// Controller of the register assigner: sequences accept, expiry, selection and commit.
// Depends on lsra_pkg for command and status types.
`default_nettype none

module lsra_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output      logic                    in_ready,
  input  wire lsra_pkg::lsra_status_t  status,
  output      lsra_pkg::lsra_cmd_t     cmd
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_EXPIRE = 4'b0010,
    ST_SELECT = 4'b0100,
    ST_COMMIT = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  // Issue commands from the current state
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXPIRE;
        end
      end
      ST_EXPIRE: begin
        if (status.expire_hit) begin
          cmd.expire = 1'b1;
        end else begin
          state_next = ST_SELECT;
        end
      end
      ST_SELECT: begin
        cmd.select = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (status.slot_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hdl/linear_scan_register_assigner.sv
// Linear-scan register assigner: top level joining the controller and the datapath.
// Depends on lsra_pkg, the channel interfaces, lsra_ctrl and lsra_dpath.
//
// Usage:
//   items   - live intervals (begin_function, range_start, range_end, fp_file),
//             sent in rising start order; one transaction per interval.
//   results - one transaction per interval: granted, reg_index, expired_count.
//   cfg     - writes of the usable masks (index 0 integer, index 1 float); always
//             ready, taken into the locked masks at the next begin_function.
// Timing: an accepted interval passes the expiry, select and commit states before
//   its result is registered; the expiry pops one entry from the sorted active
//   list per cycle. The next interval is taken once the previous one has been
//   committed, so intervals are worked one at a time.
// Reset (rst, synchronous): masks return to their reset values, free sets fill,
//   the active list empties; no clearing pass, the block is ready at once.
// Stall: a result waits in the output register while results.ready is low; the
//   next interval is still accepted and worked up to its commit, where it holds.
`default_nettype none

module linear_scan_register_assigner (
  input  wire logic    clk,
  input  wire logic    rst,
  lsra_item_if.sink    items,
  lsra_result_if.source results,
  lsra_cfg_if.sink     cfg
);

  lsra_pkg::lsra_cmd_t    cmd;
  lsra_pkg::lsra_status_t status;

  assign cfg.ready = 1'b1;

  lsra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (items.valid),
    .in_ready (items.ready),
    .status   (status),
    .cmd      (cmd)
  );

  lsra_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .begin_function (items.begin_function),
    .range_start    (items.range_start),
    .range_end      (items.range_end),
    .fp_file        (items.fp_file),
    .cfg_valid      (cfg.valid),
    .cfg_index      (cfg.index),
    .cfg_data       (cfg.data),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .granted        (results.granted),
    .reg_index      (results.reg_index),
    .expired_count  (results.expired_count)
  );

endmodule

`default_nettype wire

>>> sim/tb_linear_scan_register_assigner.sv
// Self-checking testbench for the linear-scan register assigner: directed and random intervals.
// Depends on lsra_pkg, the item, result and cfg channel interfaces and the block's RTL.
// A predictor in this file tracks free, used and locked masks and the sorted active list.
module tb_linear_scan_register_assigner;
  timeunit 1ns;
  timeprecision 1ps;
  import lsra_pkg::*;

  // One expected result transaction
  typedef struct packed {
    logic             granted;
    logic [REG_W-1:0] reg_index;
    logic [EXP_W-1:0] expired_count;
  } grant_t;

  logic clk = 1'b0;
  logic rst;

  lsra_item_if   items_ch ();
  lsra_result_if results_ch ();
  lsra_cfg_if    cfg_ch ();

  linear_scan_register_assigner i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  always #5 clk = ~clk;

  // Predictor state: usable masks, per-file masks, live intervals sorted by end
  logic [MASK_W-1:0] int_usable, flt_usable;
  logic [MASK_W-1:0] int_free_m, int_used_m, int_lock_m;
  logic [MASK_W-1:0] flt_free_m, flt_used_m, flt_lock_m;
  lsra_entry_t       live_q[$];

  grant_t pending_grants[$];
  int     mismatches = 0;
  bit     pace_items = 1'b0;
  bit     pace_results = 1'b0;

  // Refill free sets, relock from usable masks, drop all live intervals
  function automatic void open_function();
    int_free_m = '1;
    flt_free_m = '1;
    int_lock_m = ~int_usable;
    flt_lock_m = ~flt_usable;
    live_q.delete();
  endfunction

  function automatic int lowest_set(input logic [MASK_W-1:0] v);
    for (int i = 0; i < MASK_W; i++) begin
      if (v[i]) begin
        return i;
      end
    end
    return -1;
  endfunction

  // Expire, pick a register and insert by end; return the expected result
  function automatic grant_t assign_register(input logic bf, input logic [POS_W-1:0] s,
                                             input logic [POS_W-1:0] e, input logic fl);
    grant_t            g;
    int                n;
    int                pick;
    int                pos;
    logic [MASK_W-1:0] cand;
    logic [MASK_W-1:0] used_m;
    lsra_entry_t       ent;
    g    = '0;
    n    = 0;
    pick = -1;
    if (bf) begin
      open_function();
    end
    while (live_q.size() > 0 && live_q[0].end_pos < s) begin
      ent = live_q.pop_front();
      if (ent.file == FILE_FLT) begin
        flt_free_m[ent.reg_idx] = 1'b1;
      end else begin
        int_free_m[ent.reg_idx] = 1'b1;
      end
      n++;
    end
    if (live_q.size() < ACTIVE_DEPTH) begin
      cand   = (fl == FILE_FLT) ? (flt_free_m & ~flt_lock_m) : (int_free_m & ~int_lock_m);
      cand   = cand & REG_WINDOW;
      used_m = (fl == FILE_FLT) ? flt_used_m : int_used_m;
      pick   = lowest_set(cand & used_m);
      if (pick < 0) begin
        pick = lowest_set(cand);
      end
    end
    if (pick >= 0) begin
      if (fl == FILE_FLT) begin
        flt_free_m[pick] = 1'b0;
        flt_used_m[pick] = 1'b1;
      end else begin
        int_free_m[pick] = 1'b0;
        int_used_m[pick] = 1'b1;
      end
      pos = 0;
      while (pos < live_q.size() && !(e < live_q[pos].end_pos)) begin
        pos++;
      end
      ent.end_pos = e;
      ent.reg_idx = pick[REG_W-1:0];
      ent.file    = fl;
      live_q.insert(pos, ent);
      g.granted   = 1'b1;
      g.reg_index = pick[REG_W-1:0];
    end
    g.expired_count = n[EXP_W-1:0];
    return g;
  endfunction

  // Idle length: mostly none, some short, a few long
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Send one interval transaction; valid stays high for a back-to-back successor
  task automatic send_interval(input logic bf, input logic [POS_W-1:0] s,
                               input logic [POS_W-1:0] e, input logic fl);
    int gap;
    gap = pace_items ? idle_length() : 0;
    if (gap > 0) begin
      items_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    items_ch.valid          <= 1'b1;
    items_ch.begin_function <= bf;
    items_ch.range_start    <= s;
    items_ch.range_end      <= e;
    items_ch.fp_file        <= fl;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
    pending_grants.push_back(assign_register(bf, s, e, fl));
  endtask

  // Hold off the sender until every expected result has come back
  task automatic drain_results();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  // Write one usable mask; valid stays high for a following write
  task automatic write_mask(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_INT_USABLE) begin
      int_usable = val;
    end else begin
      flt_usable = val;
    end
  endtask

  task automatic set_masks(input logic [MASK_W-1:0] int_m, input logic [MASK_W-1:0] flt_m);
    drain_results();
    write_mask(CFG_INT_USABLE, int_m);
    write_mask(CFG_FLT_USABLE, flt_m);
    cfg_ch.valid <= 1'b0;
  endtask

  // Field extremes, expiry, locked register, exhausted file, restart, disorder
  task automatic test_directed();
    send_interval(1'b1, 16'd0, 16'd0, FILE_INT);
    send_interval(1'b0, 16'd0, 16'hFFFF, FILE_FLT);
    send_interval(1'b0, 16'd1, 16'd1, FILE_INT);
    send_interval(1'b0, 16'd5, 16'd2, FILE_INT);
    send_interval(1'b0, 16'd6, 16'd6, FILE_INT);
    // exhaust the eight usable float registers, last one gets nothing
    for (int k = 0; k < 8; k++) begin
      send_interval(1'b0, POS_W'(10 + k), 16'hFFFF, FILE_FLT);
    end
    // integer register four is locked by default
    for (int k = 0; k < 5; k++) begin
      send_interval(1'b0, POS_W'(20 + k), 16'd65000, FILE_INT);
    end
    send_interval(1'b0, 16'hFFFF, 16'hFFFF, FILE_INT);
    send_interval(1'b0, 16'hFFFF, 16'd0, FILE_FLT);
    send_interval(1'b1, 16'd100, 16'd200, FILE_INT);
    send_interval(1'b0, 16'd50, 16'd40, FILE_FLT);
  endtask

  // A register used earlier wins over a lower one never used
  task automatic test_used_preference();
    set_masks(INT_USABLE_RESET, 32'hFFFF_0000);
    send_interval(1'b1, 16'd0, 16'd10, FILE_FLT);
    send_interval(1'b0, 16'd1, 16'd10, FILE_FLT);
    set_masks(INT_USABLE_RESET, 32'hFFFF_FF00);
    send_interval(1'b1, 16'd20, 16'd30, FILE_FLT);
    send_interval(1'b0, 16'd21, 16'd30, FILE_FLT);
    send_interval(1'b0, 16'd22, 16'd30, FILE_FLT);
  endtask

  // Fill the active list with free registers left, then expire it whole
  task automatic test_list_full();
    set_masks('1, '1);
    send_interval(1'b1, 16'd0, 16'd60000, FILE_INT);
    for (int k = 1; k < ACTIVE_DEPTH; k++) begin
      send_interval(1'b0, POS_W'(k), 16'd60000, logic'(k % 2));
    end
    send_interval(1'b0, 16'd40, 16'd60000, FILE_FLT);
    send_interval(1'b0, 16'd60001, 16'd60001, FILE_INT);
  endtask

  // Mostly well-formed functions with random content, some noise
  task automatic run_functions(input int budget);
    int sent;
    int len;
    int pos;
    int span;
    int r;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(0, 9) == 0) begin
        send_interval($urandom_range(0, 7) == 0, POS_W'($urandom), POS_W'($urandom),
                      logic'($urandom_range(0, 1)));
        sent++;
      end else begin
        len = $urandom_range(1, 40);
        pos = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 2000);
        for (int k = 0; k < len && sent < budget; k++) begin
          r = $urandom_range(0, 99);
          if (r < 5) begin
            pos = pos - $urandom_range(1, 20);
          end else if (r < 90) begin
            pos = pos + $urandom_range(0, 4);
          end else begin
            pos = pos + $urandom_range(5, 400);
          end
          pos = (pos < 0) ? 0 : ((pos > 65535) ? 65535 : pos);
          r = $urandom_range(0, 99);
          if (r < 70) begin
            span = pos + $urandom_range(0, 15);
          end else if (r < 85) begin
            span = pos + $urandom_range(0, 3000);
          end else if (r < 95) begin
            span = $urandom_range(0, pos);
          end else begin
            span = $urandom_range(0, 65535);
          end
          span = (span > 65535) ? 65535 : span;
          send_interval(k == 0, POS_W'(pos), POS_W'(span), logic'($urandom_range(0, 1)));
          sent++;
        end
      end
    end
  endtask

  // Random phases, each with its own masks and idling mode
  task automatic test_random_phases();
    logic [MASK_W-1:0] int_m, flt_m;
    for (int p = 0; p < 10; p++) begin
      int_m = $urandom;
      flt_m = $urandom;
      case (p)
        0: begin
          int_m = '1;
          flt_m = '1;
        end
        1: begin
          int_m = '0;
        end
        2: begin
          int_m = INT_USABLE_RESET;
          flt_m = '0;
        end
        3: begin
          flt_m = FLT_USABLE_RESET;
        end
        4: begin
          int_m = 32'h0000_0001;
          flt_m = 32'h8000_0001;
        end
        5: begin
          int_m = 32'h8000_0000;
        end
        default: ;
      endcase
      set_masks(int_m, flt_m);
      pace_items   = (p % 4 == 1) || (p % 4 == 2);
      pace_results = (p % 4 == 1) || (p % 4 == 3);
      run_functions(89);
    end
  endtask

  // Drive the result ready with random stalls
  initial begin
    int stall;
    results_ch.ready = 1'b0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (stall > 0) begin
        results_ch.ready <= 1'b0;
        stall--;
      end else begin
        results_ch.ready <= 1'b1;
        if (pace_results) begin
          stall = idle_length();
        end
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    grant_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (pending_grants.size() == 0) begin
        $error("result with no interval outstanding: granted %0d reg %0d expired %0d",
               results_ch.granted, results_ch.reg_index, results_ch.expired_count);
        mismatches++;
      end else begin
        want = pending_grants.pop_front();
        if (results_ch.granted !== want.granted) begin
          $error("granted: expected %0d, got %0d", want.granted, results_ch.granted);
          mismatches++;
        end
        if (results_ch.reg_index !== want.reg_index) begin
          $error("reg_index: expected %0d, got %0d", want.reg_index, results_ch.reg_index);
          mismatches++;
        end
        if (results_ch.expired_count !== want.expired_count) begin
          $error("expired_count: expected %0d, got %0d",
                 want.expired_count, results_ch.expired_count);
          mismatches++;
        end
      end
    end
  end

  // Stop a hung run
  initial begin
    #8_000_000;
    $display("FAIL linear_scan_register_assigner");
    $finish;
  end

  initial begin
    rst                     = 1'b1;
    items_ch.valid          = 1'b0;
    items_ch.begin_function = 1'b0;
    items_ch.range_start    = '0;
    items_ch.range_end      = '0;
    items_ch.fp_file        = 1'b0;
    cfg_ch.valid            = 1'b0;
    cfg_ch.index            = CFG_INT_USABLE;
    cfg_ch.data             = '0;
    int_usable              = INT_USABLE_RESET;
    flt_usable              = FLT_USABLE_RESET;
    int_used_m              = '0;
    flt_used_m              = '0;
    open_function();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_used_preference();
    test_list_full();
    test_random_phases();

    // Let the last results arrive, then watch for strays
    drain_results();
    repeat (40) @(posedge clk);
    if (mismatches == 0 && pending_grants.size() == 0) begin
      $display("PASS linear_scan_register_assigner");
    end else begin
      $display("FAIL linear_scan_register_assigner");
    end
    $finish;
  end

endmodule
